FILE: design/cac_pkg.sv
// Shared types, constants and codes for the conductivity average and compensate unit.
package cac_pkg;

  // Field widths of the sample and result beats, the offset and the accumulator.
  localparam int ADC_W    = 10;
  localparam int TEMP_W   = 12;
  localparam int OFS_W    = 12;
  localparam int COND_W   = 15;
  localparam int SUM_W    = 16;
  localparam int CNT_W    = 6;

  // Default group size.
  localparam int SAMPLES_PER_READING_DEF = 40;

  // Divider widths: the compensation divide needs a 38-bit dividend
  // and an 18-bit positive coefficient as divisor.
  localparam int DIVIDEND_W = 38;
  localparam int DIVISOR_W  = 18;

  // Intermediate widths.
  localparam int SCALED_W = 27;   // sum * 1250 + N/2
  localparam int VOLT_W   = 21;   // average voltage, Q.8 mV
  localparam int TPROD_W  = 29;   // 19399 * (T - 400)
  localparam int COEF_W   = 19;   // signed Q2.16 coefficient
  localparam int PCOMP_W  = 20;   // compensated voltage, Q.8 mV, in range
  localparam int SEGP_W   = 30;   // slope * P
  localparam int X_W      = 32;   // signed segment value, 25600 per uS/cm

  // Final scaling by 1/100 as a reciprocal multiply, exact for 24-bit operands.
  localparam int OUT_SHIFT  = 31;
  localparam int OUT_PROD_W = 49;
  localparam int OUT_Q_W    = 18;

  // Calibration offset after reset, in uS/cm.
  localparam logic signed [OFS_W-1:0] OFFSET_RESET = 12'sd150;

  // Arithmetic constants.
  localparam logic [SCALED_W-1:0]      MV_SCALE   = 27'd1250;
  localparam logic signed [15:0]       COEF_K     = 16'sd19399;
  localparam logic signed [12:0]       TEMP_REF   = 13'sd400;
  localparam logic signed [COEF_W-1:0] COEF_ONE   = 19'sd65536;
  localparam logic signed [15:0]       OFS_SCALE  = 16'sd25600;
  localparam logic [DIVIDEND_W-1:0]    P_MAX      = 38'd844800;   // 3300 mV
  localparam logic [PCOMP_W-1:0]       SEG1_TOP   = 20'd114688;   // 448 mV
  localparam logic [PCOMP_W-1:0]       SEG2_TOP   = 20'd372992;   // 1457 mV
  localparam logic [9:0]               SLOPE_LOW  = 10'd684;
  localparam logic [9:0]               SLOPE_MID  = 10'd698;
  localparam logic [9:0]               SLOPE_HIGH = 10'd530;
  localparam logic signed [X_W-1:0]    BIAS_LOW   = -32'sd1646592;
  localparam logic signed [X_W-1:0]    BIAS_MID   = -32'sd3251200;
  localparam logic signed [X_W-1:0]    BIAS_HIGH  = 32'sd58316800;
  localparam logic signed [X_W-1:0]    ROUND_HALF = 32'sd12800;
  localparam logic [24:0]              OUT_RECIP  = 25'd21474837;  // ceil(2^31 / 100)
  localparam logic [OUT_Q_W-1:0]       COND_MAX   = 18'd32767;

  // Range status codes.
  typedef enum logic [1:0] {
    RANGE_OK    = 2'd0,
    RANGE_BELOW = 2'd1,
    RANGE_ABOVE = 2'd2
  } cac_range_t;

  // Sample beat.
  typedef struct packed {
    logic [ADC_W-1:0]         adc_sample;
    logic signed [TEMP_W-1:0] water_temp_sixteenths;
  } cac_in_t;

  // Result beat.
  typedef struct packed {
    logic [COND_W-1:0] conductivity_us_per_cm;
    cac_range_t        range_status;
  } cac_out_t;

  // Kind of result loaded into the output register.
  typedef enum logic [1:0] {
    RES_ABOVE,
    RES_ZERO,
    RES_VALUE
  } cac_res_sel_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_COEF_MUL,
    ST_COEF_FIX,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SEG_MUL,
    ST_SEG_SUM,
    ST_OUT_SCALE,
    ST_OUT_ABOVE,
    ST_OUT_ZERO,
    ST_OUT_VALUE
  } cac_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         accept;
    logic         scale;
    logic         coef_mul;
    logic         avg;
    logic         coef_fix;
    logic         div_start;
    logic         cap_p;
    logic         seg_mul;
    logic         seg_sum;
    logic         out_scale;
    logic         load_res;
    cac_res_sel_t res_sel;
  } cac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_sample;
    logic div_done;
    logic coef_bad;
    logic p_over;
    logic x_pos;
  } cac_stat_t;

endpackage

FILE: design/cac_div.sv
// Restoring divider, one quotient bit per cycle, for the temperature compensation divide.
module cac_div import cac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEPS  = DIVIDEND_W;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic                  active;
  logic [STEP_W-1:0]     steps_left;
  logic [DIVISOR_W-1:0]  div_q;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVIDEND_W-1:0] quo_next;

  // One shift-and-subtract step.
  always_comb begin
    trial    = {rem, quo[DIVIDEND_W-1]};
    fits     = trial >= {1'b0, div_q};
    rem_next = fits ? DIVISOR_W'(trial - {1'b0, div_q}) : DIVISOR_W'(trial);
    quo_next = {quo[DIVIDEND_W-2:0], fits};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active     <= 1'b1;
        steps_left <= STEP_W'(STEPS);
      end else if (active) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers; the dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      div_q <= divisor;
      rem   <= '0;
      quo   <= dividend;
    end else if (active) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

FILE: design/cac_dp.sv
// Datapath: sample accumulation, fixed-point conversion stages and the result register.
module cac_dp import cac_pkg::*; #(
  parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cac_cmd_t                cmd,
  input  cac_in_t                 sample,
  input  logic                    cfg_write,
  input  logic signed [OFS_W-1:0] cfg_data,
  output cac_stat_t               stat,
  output cac_out_t                result
);

  // The average divides by the group size through a reciprocal multiply. With the
  // shift at SCALED_W + clog2(N) the rounded-up reciprocal is exact for any dividend
  // below 2^SCALED_W.
  localparam int AVG_SHIFT   = SCALED_W + $clog2(SAMPLES_PER_READING);
  localparam int AVG_RECIP_W = SCALED_W + 1;
  localparam int AVG_PROD_W  = SCALED_W + AVG_RECIP_W;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(
      ((64'd1 << AVG_SHIFT) + 64'(SAMPLES_PER_READING) - 64'd1) /
      64'(SAMPLES_PER_READING));

  localparam logic [CNT_W:0]        GROUP_N = (CNT_W + 1)'(SAMPLES_PER_READING);
  localparam logic [SCALED_W-1:0]   HALF_N  = SCALED_W'(SAMPLES_PER_READING / 2);

  logic [SUM_W-1:0]           sum;
  logic [CNT_W-1:0]           count;
  logic signed [OFS_W-1:0]    offset;
  logic [SUM_W-1:0]           grp_sum;
  logic signed [TEMP_W-1:0]   temp_q;
  logic [SCALED_W-1:0]        sum_scaled;
  logic signed [TPROD_W-1:0]  tprod;
  logic signed [COEF_W-1:0]   coef;
  logic signed [X_W-1:0]      ofs_term;
  logic [VOLT_W-1:0]          v;
  logic [PCOMP_W-1:0]         p;
  logic [SEGP_W-1:0]          segprod;
  logic signed [X_W-1:0]      seg_off;
  logic signed [X_W-1:0]      x;
  logic [COND_W-1:0]          cond;
  cac_out_t                   result_q;

  logic [SUM_W-1:0]           sum_add;
  logic signed [12:0]         temp_diff;
  logic signed [TPROD_W-1:0]  tprod_rnd;
  logic [9:0]                 slope;
  logic signed [X_W-1:0]      bias;
  logic signed [X_W-1:0]      x_rnd;
  logic [AVG_PROD_W-1:0]      avg_prod;
  logic [OUT_PROD_W-1:0]      out_prod;
  logic [OUT_Q_W-1:0]         out_quo;
  logic [DIVIDEND_W-1:0]      div_dividend;
  logic [DIVISOR_W-1:0]       div_divisor;
  logic                       div_done;
  logic [DIVIDEND_W-1:0]      div_quo;
  logic [COND_W-1:0]          cond_sat;

  // Running sum and count of the current group.
  assign sum_add          = sum + SUM_W'(sample.adc_sample);
  assign stat.last_sample = ({1'b0, count} + 1'b1) == GROUP_N;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      if (stat.last_sample) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_add;
        count <= count + 1'b1;
      end
    end
  end

  // Calibration offset register.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= OFFSET_RESET;
    end else if (cfg_write) begin
      offset <= cfg_data;
    end
  end

  // Segment slope and bias from the compensated voltage.
  always_comb begin
    if (p <= SEG1_TOP) begin
      slope = SLOPE_LOW;
      bias  = BIAS_LOW;
    end else if (p <= SEG2_TOP) begin
      slope = SLOPE_MID;
      bias  = BIAS_MID;
    end else begin
      slope = SLOPE_HIGH;
      bias  = BIAS_HIGH;
    end
  end

  assign temp_diff = $signed({temp_q[TEMP_W-1], temp_q}) - TEMP_REF;
  assign tprod_rnd = tprod + TPROD_W'(128);
  assign x_rnd     = x + ROUND_HALF;

  // Reciprocal multiplies for the average and for the final scaling by 1/25600.
  assign avg_prod = AVG_PROD_W'(sum_scaled) * AVG_PROD_W'(AVG_RECIP);
  assign out_prod = OUT_PROD_W'(x_rnd[X_W-1:8]) * OUT_PROD_W'(OUT_RECIP);
  assign out_quo  = out_prod[OUT_SHIFT +: OUT_Q_W];

  // Saturate the final quotient.
  assign cond_sat = (out_quo > COND_MAX) ? '1 : out_quo[COND_W-1:0];

  // Conversion stage registers, each loaded on its step command.
  always_ff @(posedge clk) begin
    if (cmd.accept && stat.last_sample) begin
      grp_sum <= sum_add;
      temp_q  <= sample.water_temp_sixteenths;
    end
    if (cmd.scale) begin
      sum_scaled <= SCALED_W'(grp_sum) * MV_SCALE + HALF_N;
    end
    if (cmd.coef_mul) begin
      tprod <= COEF_K * temp_diff;
    end
    if (cmd.avg) begin
      v <= avg_prod[AVG_SHIFT +: VOLT_W];
    end
    if (cmd.coef_fix) begin
      coef     <= COEF_ONE + COEF_W'(tprod_rnd >>> 8);
      ofs_term <= offset * OFS_SCALE;
    end
    if (cmd.cap_p) begin
      p <= div_quo[PCOMP_W-1:0];
    end
    if (cmd.seg_mul) begin
      segprod <= SEGP_W'(p) * SEGP_W'(slope);
      seg_off <= bias;
    end
    if (cmd.seg_sum) begin
      x <= $signed({2'b00, segprod}) + seg_off + ofs_term;
    end
    if (cmd.out_scale) begin
      cond <= cond_sat;
    end
  end

  // Compensation divide operands, with half the coefficient added for rounding.
  assign div_dividend = {1'b0, v, 16'b0} + DIVIDEND_W'(coef[DIVISOR_W-1:1]);
  assign div_divisor  = coef[DIVISOR_W-1:0];

  cac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Status back to the controller.
  assign stat.div_done = div_done;
  assign stat.coef_bad = coef <= $signed(COEF_W'(0));
  assign stat.p_over   = div_quo > P_MAX;
  assign stat.x_pos    = x > $signed(X_W'(0));

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      case (cmd.res_sel)
        RES_ABOVE: begin
          result_q.conductivity_us_per_cm <= '0;
          result_q.range_status           <= RANGE_ABOVE;
        end
        RES_ZERO: begin
          result_q.conductivity_us_per_cm <= '0;
          result_q.range_status           <= RANGE_OK;
        end
        RES_VALUE: begin
          result_q.conductivity_us_per_cm <= cond;
          result_q.range_status           <= RANGE_OK;
        end
        default: begin
          result_q.conductivity_us_per_cm <= '0;
          result_q.range_status           <= RANGE_ABOVE;
        end
      endcase
    end
  end

  assign result = result_q;

endmodule

FILE: design/cac_ctrl.sv
// Controller: sequences accumulation, conversion steps and result delivery.
module cac_ctrl import cac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      sample_valid,
  input  logic      result_stall,
  input  cac_stat_t stat,
  output logic      sample_stall,
  output logic      result_valid,
  output cac_cmd_t  cmd
);

  cac_state_t state;
  cac_state_t state_next;
  logic       result_valid_next;
  logic       out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !result_valid || !result_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_valid && stat.last_sample) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE:      state_next = ST_COEF_MUL;
      ST_COEF_MUL:   state_next = ST_COEF_FIX;
      ST_COEF_FIX:   state_next = ST_DIV_START;
      ST_DIV_START:  state_next = stat.coef_bad ? ST_OUT_ABOVE : ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_next = stat.p_over ? ST_OUT_ABOVE : ST_SEG_MUL;
        end
      end
      ST_SEG_MUL:    state_next = ST_SEG_SUM;
      ST_SEG_SUM:    state_next = ST_OUT_SCALE;
      ST_OUT_SCALE:  state_next = stat.x_pos ? ST_OUT_VALUE : ST_OUT_ZERO;
      ST_OUT_ABOVE, ST_OUT_ZERO, ST_OUT_VALUE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd          = '0;
    cmd.res_sel  = RES_VALUE;
    sample_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE:       cmd.accept = sample_valid;
      ST_SCALE:      cmd.scale = 1'b1;
      ST_COEF_MUL: begin
        cmd.coef_mul = 1'b1;
        cmd.avg      = 1'b1;
      end
      ST_COEF_FIX:   cmd.coef_fix = 1'b1;
      ST_DIV_START:  cmd.div_start = !stat.coef_bad;
      ST_DIV_WAIT:   cmd.cap_p = stat.div_done;
      ST_SEG_MUL:    cmd.seg_mul = 1'b1;
      ST_SEG_SUM:    cmd.seg_sum = 1'b1;
      ST_OUT_SCALE:  cmd.out_scale = 1'b1;
      ST_OUT_ABOVE: begin
        cmd.load_res = out_free;
        cmd.res_sel  = RES_ABOVE;
      end
      ST_OUT_ZERO: begin
        cmd.load_res = out_free;
        cmd.res_sel  = RES_ZERO;
      end
      ST_OUT_VALUE: begin
        cmd.load_res = out_free;
        cmd.res_sel  = RES_VALUE;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Result valid flag: set on load, cleared when the beat is taken.
  always_comb begin
    result_valid_next = result_valid;
    if (cmd.load_res) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // A result appears only out of one of the output states.
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_OUT_ABOVE || state == ST_OUT_ZERO ||
                                  state == ST_OUT_VALUE))
    else $error("result valid rose outside an output state");

  // The divider finishes only while the controller waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> state == ST_DIV_WAIT)
    else $error("divider done outside the wait state");

  // The last sample of a group starts a conversion.
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && sample_valid && stat.last_sample) |=> state == ST_SCALE)
    else $error("last sample did not start a conversion");

endmodule

FILE: design/conductivity_average_compensate_unit.sv
// A sample that does not close its group is absorbed by the accumulator. The closing
// sample's result passes the scale, coefficient, 38-step compensation divide, segment
// and output steps; above range after the divide it skips the segment and output steps,
// and a bad coefficient also skips the divide. Throughput: one sample per cycle within a
// group; sample_stall stays high from the closing sample until its result is loaded.
// Reset (synchronous): clears sum, count, controller and result valid; offset = 150.
module conductivity_average_compensate_unit import cac_pkg::*; #(
  parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  cac_in_t                 sample,
  output logic                    result_valid,
  input  logic                    result_stall,
  output cac_out_t                result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic signed [OFS_W-1:0] cfg_data
);

  cac_cmd_t  cmd;
  cac_stat_t stat;

  // The offset register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  cac_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  cac_dp #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sample    (sample),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .result    (result)
  );

endmodule

FILE: test/conductivity_average_compensate_unit_tb.sv
// Self-checking testbench for the conductivity average and compensate unit.
`timescale 1ns / 1ps

module conductivity_average_compensate_unit_tb;
  import cac_pkg::*;

  localparam int READING_SIZE  = 40;      // samples per reading
  localparam int SETTLE_CYCLES = 200;     // covers one full conversion
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_CHUNKS = 6;
  localparam int CHUNK_READINGS = 2;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  cac_in_t                 sample_beat = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  cac_out_t                result_beat;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic signed [OFS_W-1:0] cfg_data = '0;

  // Stimulus waiting for the driver, and readings expected from the block.
  cac_in_t  samples_pending [$];
  cac_out_t readings_due [$];
  cac_out_t due_reading;

  // Local copy of the accumulator and the calibration register.
  logic [SUM_W-1:0]        group_sum = '0;
  int                      group_count = 0;
  logic signed [OFS_W-1:0] offset_setting = OFFSET_RESET;
  logic signed [OFS_W-1:0] offset_sweep [RANDOM_CHUNKS];

  int samples_outstanding = 0;
  int readings_checked = 0;
  int error_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  conductivity_average_compensate_unit #(
    .SAMPLES_PER_READING(READING_SIZE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample_beat),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_beat),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Averages a finished group, applies temperature compensation, maps it through the
  // three probe segments, adds the calibration offset, and checks range and saturation.
  function automatic cac_out_t compensate_reading(input logic [SUM_W-1:0] sum,
                                                  input logic signed [TEMP_W-1:0] temp,
                                                  input logic signed [OFS_W-1:0] cal_offset);
    longint   volts;
    longint   coef;
    longint   comp;
    longint   seg;
    cac_out_t reading;
    reading.conductivity_us_per_cm = '0;
    reading.range_status = RANGE_OK;
    volts = (longint'(sum) * 1250 + READING_SIZE / 2) / READING_SIZE;
    coef = 65536 + ((longint'(19399) * (longint'(temp) - 400) + 128) >>> 8);
    if (coef <= 0) begin
      // Water too cold for a usable coefficient.
      reading.range_status = RANGE_ABOVE;
    end else begin
      comp = (volts * 65536 + coef / 2) / coef;
      if (comp > 3300 * 256) begin
        reading.range_status = RANGE_ABOVE;
      end else begin
        if (comp <= 448 * 256) begin
          seg = 684 * comp - 6432 * 256;
        end else if (comp <= 1457 * 256) begin
          seg = 698 * comp - 12700 * 256;
        end else begin
          seg = 530 * comp + 227800 * 256;
        end
        seg = seg + longint'(cal_offset) * 25600;
        // A non-positive value reads as zero but stays in range.
        if (seg > 0) begin
          seg = (seg + 12800) / 25600;
          if (seg > 32767) seg = 32767;
          reading.conductivity_us_per_cm = COND_W'(seg);
        end
      end
    end
    return reading;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Queues one group whose samples add up to the given total.
  task automatic queue_sum_group(input int total, input int close_temp);
    cac_in_t item;
    for (int i = 0; i < READING_SIZE; i++) begin
      item.adc_sample = ADC_W'(total / READING_SIZE + ((i < total % READING_SIZE) ? 1 : 0));
      item.water_temp_sixteenths = (i == READING_SIZE - 1) ? TEMP_W'(close_temp)
                                                           : TEMP_W'($urandom);
      samples_pending.push_back(item);
      samples_outstanding++;
    end
  endtask

  // Queues one group with a random level, spread and closing temperature.
  task automatic queue_random_group();
    cac_in_t item;
    int      style;
    int      level;
    int      spread;
    int      value;
    int      roll;
    int      close_temp;
    style = $urandom_range(0, 99);
    level = $urandom_range(0, 1023);
    spread = $urandom_range(0, 40);
    if (style < 10) begin
      level = ($urandom_range(0, 1) != 0) ? 1023 : 0;
      spread = 0;
    end else if (style < 25) begin
      // Levels near the segment breakpoints and the top of the range.
      case ($urandom_range(0, 2))
        0: level = 92;
        1: level = 298;
        default: level = 676;
      endcase
      spread = $urandom_range(0, 3);
    end else if (style >= 75) begin
      level = 512;
      spread = 512;
    end
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      close_temp = int'($urandom_range(0, 2880)) - 880;
    end else if (roll < 80) begin
      close_temp = int'($urandom_range(0, 30)) - 480;
    end else if (roll < 90) begin
      close_temp = int'($urandom_range(0, 4095)) - 2048;
    end else begin
      close_temp = int'($urandom_range(0, 400)) + 200;
    end
    for (int i = 0; i < READING_SIZE; i++) begin
      value = level + int'($urandom_range(0, 2 * spread)) - spread;
      if (value < 0) value = 0;
      if (value > 1023) value = 1023;
      item.adc_sample = ADC_W'(value);
      item.water_temp_sixteenths = (i == READING_SIZE - 1) ? TEMP_W'(close_temp)
                                                           : TEMP_W'($urandom);
      samples_pending.push_back(item);
      samples_outstanding++;
    end
  endtask

  // Waits until every queued sample is taken and every reading has arrived,
  // then lets a full conversion time pass.
  task automatic wait_idle();
    while (samples_outstanding != 0 || readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(input logic signed [OFS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    offset_setting = value;
  endtask

  // Sample driver: predicts on each accepted beat, then presents the next one.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        samples_outstanding--;
        group_sum = group_sum + SUM_W'(sample_beat.adc_sample);
        group_count++;
        if (group_count == READING_SIZE) begin
          readings_due.push_back(compensate_reading(group_sum,
                                 sample_beat.water_temp_sixteenths, offset_setting));
          group_sum = '0;
          group_count = 0;
        end
      end
      // A stalled beat is held unchanged.
      if (!sample_valid || !sample_stall) begin
        if (samples_pending.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          sample_beat <= samples_pending.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (readings_due.size() == 0) begin
          report_mismatch($sformatf("unexpected reading: cond %0d status %0d",
                                    result_beat.conductivity_us_per_cm,
                                    result_beat.range_status));
        end else begin
          due_reading = readings_due.pop_front();
          if (result_beat.conductivity_us_per_cm !== due_reading.conductivity_us_per_cm) begin
            report_mismatch($sformatf("reading %0d: conductivity %0d, expected %0d",
                                      readings_checked, result_beat.conductivity_us_per_cm,
                                      due_reading.conductivity_us_per_cm));
          end
          if (result_beat.range_status !== due_reading.range_status) begin
            report_mismatch($sformatf("reading %0d: status %0d, expected %0d",
                                      readings_checked, result_beat.range_status,
                                      due_reading.range_status));
          end
          readings_checked++;
        end
      end
      result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Watchdog on total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Main sequence: directed groups at the reset offset, then random chunks,
  // each under its own calibration setting.
  initial begin
    offset_sweep[0] = 12'sd2047;
    offset_sweep[1] = -12'sd2048;
    offset_sweep[2] = -12'sd2000;
    offset_sweep[3] = 12'sd2000;
    offset_sweep[4] = 12'sd0;
    offset_sweep[5] = OFS_W'($urandom);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_idle_pct = 18;
    receiver_stall_pct = 82;

    // Empty probe, full-scale probe in normal and hot water, half-scale in frozen water.
    queue_sum_group(0, 400);
    queue_sum_group(40920, 400);
    queue_sum_group(40920, 2047);
    queue_sum_group(20480, -2048);
    // Coefficient just below and just above zero.
    queue_sum_group(0, -465);
    queue_sum_group(0, -464);
    queue_sum_group(40, -464);
    // Both sides of each breakpoint and of the top of the range.
    queue_sum_group(3670, 400);
    queue_sum_group(3671, 400);
    queue_sum_group(11935, 400);
    queue_sum_group(11936, 400);
    queue_sum_group(27033, 400);
    queue_sum_group(27034, 400);
    // Temperature ends of the normal span.
    queue_sum_group(20000, -880);
    queue_sum_group(20000, 2000);
    wait_idle();

    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      if (chunk == 2) begin
        sender_idle_pct = 82;
        receiver_stall_pct = 18;
      end else if (chunk == 4) begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      write_offset(offset_sweep[chunk]);
      repeat (CHUNK_READINGS) queue_random_group();
      wait_idle();
    end

    if (readings_due.size() != 0) begin
      report_mismatch($sformatf("%0d readings never arrived", readings_due.size()));
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/cac_pkg.sv
design/cac_div.sv
design/cac_dp.sv
design/cac_ctrl.sv
design/conductivity_average_compensate_unit.sv
test/conductivity_average_compensate_unit_tb.sv
